FILE: src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Recursive lock table package
// Shared field widths, operation and status codes, and word structs.
// ----------------------------------------------------------------------------
package rlt_pkg;

	localparam int LOCK_COUNT_DEF      = 16;
	localparam int COUNT_WIDTH_DEF     = 16;
	localparam int THREAD_ID_WIDTH_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int TID_W    = 32;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_ACQUIRE = 2'd2,
		MODE_RELEASE = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_ERROR     = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [INDEX_W-1:0] lock_index;
		logic [TID_W-1:0]   thread_id;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] granted_index;
		logic [DEPTH_W-1:0] depth_after;
	} rsp_t;

endpackage

FILE: src/rlt_req_if.sv
// ----------------------------------------------------------------------------
// Lock request channel
// Valid/ready channel carrying one lock operation per word.
// ----------------------------------------------------------------------------
interface rlt_req_if;
	logic                       valid;
	logic                       ready;
	logic [rlt_pkg::MODE_W-1:0]  mode;
	logic [rlt_pkg::INDEX_W-1:0] lock_index;
	logic [rlt_pkg::TID_W-1:0]   thread_id;

	modport source (output valid, output mode, output lock_index, output thread_id,
		input ready);
	modport sink (input valid, input mode, input lock_index, input thread_id,
		output ready);
endinterface

FILE: src/rlt_rsp_if.sv
// ----------------------------------------------------------------------------
// Lock response channel
// Valid/ready channel carrying one operation result per word.
// ----------------------------------------------------------------------------
interface rlt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rlt_pkg::STATUS_W-1:0] status;
	logic [rlt_pkg::INDEX_W-1:0]  granted_index;
	logic [rlt_pkg::DEPTH_W-1:0]  depth_after;

	modport source (output valid, output status, output granted_index,
		output depth_after, input ready);
	modport sink (input valid, input status, input granted_index,
		input depth_after, output ready);
endinterface

FILE: src/rlt_first_free.sv
// ----------------------------------------------------------------------------
// Lowest free entry finder
// Priority encoder over the used marks of the lock pool.
// ----------------------------------------------------------------------------
module rlt_first_free #(
	parameter int LOCK_COUNT = rlt_pkg::LOCK_COUNT_DEF,
	parameter int IDX_W      = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1
) (
	input  logic [LOCK_COUNT-1:0] used,
	output logic                  found,
	output logic [IDX_W-1:0]      index
);

	always_comb begin
		found = 1'b0;
		index = '0;
		// Scan downward so the lowest free entry is the one left standing.
		for (int i = LOCK_COUNT - 1; i >= 0; i--) begin
			if (!used[i]) begin
				found = 1'b1;
				index = IDX_W'(i);
			end
		end
	end

endmodule

FILE: src/rlt_engine.sv
// ----------------------------------------------------------------------------
// Lock table engine
// Holds the pool state and resolves one operation per cycle, committing it when commit is set.
// ----------------------------------------------------------------------------
module rlt_engine #(
	parameter int LOCK_COUNT      = rlt_pkg::LOCK_COUNT_DEF,
	parameter int COUNT_WIDTH     = rlt_pkg::COUNT_WIDTH_DEF,
	parameter int THREAD_ID_WIDTH = rlt_pkg::THREAD_ID_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rlt_pkg::req_t req,
	input  logic          commit,
	output rlt_pkg::rsp_t rsp
);
	import rlt_pkg::*;

	localparam int IDX_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam logic [8:0] LOCK_LIMIT = 9'(LOCK_COUNT);

	logic [LOCK_COUNT-1:0]      used_q;
	logic [THREAD_ID_WIDTH-1:0] owner_q [LOCK_COUNT];
	logic [COUNT_WIDTH-1:0]     count_q [LOCK_COUNT];

	logic                       free_found;
	logic [IDX_W-1:0]           free_idx;
	logic                       idx_ok;
	logic [IDX_W-1:0]           e;
	logic [THREAD_ID_WIDTH-1:0] tid;
	logic [THREAD_ID_WIDTH-1:0] cur_owner;
	logic [COUNT_WIDTH-1:0]     cur_count;
	logic [COUNT_WIDTH-1:0]     count_inc;
	logic [COUNT_WIDTH-1:0]     count_dec;
	logic                       tid_zero;
	logic                       acq_ok;
	logic                       rel_ok;

	rlt_first_free #(
		.LOCK_COUNT(LOCK_COUNT),
		.IDX_W     (IDX_W)
	) u_first_free (
		.used (used_q),
		.found(free_found),
		.index(free_idx)
	);

	always_comb begin
		idx_ok    = {5'b0, req.lock_index} < LOCK_LIMIT;
		e         = IDX_W'(req.lock_index);
		tid       = THREAD_ID_WIDTH'(req.thread_id);
		tid_zero  = (tid == '0);
		// An out-of-range index reads as an empty entry.
		cur_owner = idx_ok ? owner_q[e] : '0;
		cur_count = idx_ok ? count_q[e] : '0;
		count_inc = cur_count + COUNT_WIDTH'(1);
		count_dec = cur_count - COUNT_WIDTH'(1);
		acq_ok    = idx_ok && !tid_zero && (cur_owner == tid || cur_owner == '0)
			&& !(&cur_count);
		rel_ok    = idx_ok && !tid_zero && cur_owner == tid && cur_count != '0;

		rsp.status        = ST_OK;
		rsp.granted_index = req.lock_index;
		rsp.depth_after   = DEPTH_W'(cur_count);
		unique case (req.mode)
			MODE_ALLOC: begin
				rsp.depth_after = '0;
				if (free_found) begin
					rsp.granted_index = INDEX_W'(free_idx);
				end else begin
					rsp.status        = ST_EXHAUSTED;
					rsp.granted_index = '0;
				end
			end
			MODE_FREE: begin
				if (!idx_ok) rsp.status = ST_ERROR;
			end
			MODE_ACQUIRE: begin
				if (!idx_ok || tid_zero) begin
					rsp.status = ST_ERROR;
				end else if (cur_owner != tid && cur_owner != '0) begin
					rsp.status = ST_BUSY;
				end else if (&cur_count) begin
					rsp.status = ST_ERROR;
				end else begin
					rsp.depth_after = DEPTH_W'(count_inc);
				end
			end
			MODE_RELEASE: begin
				if (rel_ok) rsp.depth_after = DEPTH_W'(count_dec);
				else rsp.status = ST_ERROR;
			end
			default: rsp.status = ST_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < LOCK_COUNT; i++) begin
				owner_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else if (commit) begin
			unique case (req.mode)
				MODE_ALLOC: begin
					if (free_found) begin
						used_q[free_idx]  <= 1'b1;
						owner_q[free_idx] <= '0;
						count_q[free_idx] <= '0;
					end
				end
				MODE_FREE: begin
					if (idx_ok) used_q[e] <= 1'b0;
				end
				MODE_ACQUIRE: begin
					if (acq_ok) begin
						owner_q[e] <= tid;
						count_q[e] <= count_inc;
					end
				end
				MODE_RELEASE: begin
					if (rel_ok) begin
						count_q[e] <= count_dec;
						if (count_dec == '0) owner_q[e] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// A lock is held exactly when its nesting count is nonzero.
	a_owner_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> ((cur_count != '0) == (cur_owner != '0)))
		else $error("owner and count disagree");

	// Exhaustion is reported only when every entry is in use.
	a_exhausted_full: assert property (@(posedge clk) disable iff (!arst_n)
		(req.mode == MODE_ALLOC && rsp.status == ST_EXHAUSTED) |-> (&used_q))
		else $error("exhausted with a free entry");

	// A granted acquire leaves the caller as owner.
	a_acquire_owns: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && req.mode == MODE_ACQUIRE && rsp.status == ST_OK)
		|=> owner_q[$past(e)] == $past(tid))
		else $error("acquire did not take ownership");

	// A granted allocate marks its entry used.
	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && req.mode == MODE_ALLOC && free_found) |=> used_q[$past(free_idx)])
		else $error("allocate did not mark the entry");

endmodule

FILE: src/recursive_lock_table.sv
// ----------------------------------------------------------------------------
// Recursive lock table
// Pool of recursive locks with allocate, free, try-acquire and release.
// ----------------------------------------------------------------------------
//
//   Channel  Role   Word fields
//   -------  -----  ------------------------------------------------
//   req      sink   mode, lock_index, thread_id
//   rsp      source status, granted_index, depth_after
//
// One request word is taken per cycle while the response is not stalled; each
// produces exactly one response word, which passes from the input register
// into the result register and waits there until it is taken.
// The read-modify-write of the addressed entry and the lowest-free search
// happen in the single logic stage between the input and result registers.
// A stalled response holds the result register; the input register still
// drains into it at the same edge at which the response is taken.
// arst_n clears all valid flags and the whole pool: every entry is unused,
// unowned and at count zero.
//
module recursive_lock_table #(
	parameter int LOCK_COUNT      = rlt_pkg::LOCK_COUNT_DEF,
	parameter int COUNT_WIDTH     = rlt_pkg::COUNT_WIDTH_DEF,
	parameter int THREAD_ID_WIDTH = rlt_pkg::THREAD_ID_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rlt_req_if.sink   req,
	rlt_rsp_if.source rsp
);
	import rlt_pkg::*;

	// Input register: the accepted request word.
	logic valid_s1;
	req_t req_s1;

	// Result register: the response word waiting to be taken.
	logic valid_s2;
	rsp_t rsp_s2;

	rsp_t next_rsp;
	logic advance;

	// The request in stage one moves on when the result register is empty
	// or is being emptied this cycle; the pool state commits at that edge,
	// so the following request already sees the update.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.mode       <= mode_t'(req.mode);
			req_s1.lock_index <= req.lock_index;
			req_s1.thread_id  <= req.thread_id;
		end
	end

	rlt_engine #(
		.LOCK_COUNT     (LOCK_COUNT),
		.COUNT_WIDTH    (COUNT_WIDTH),
		.THREAD_ID_WIDTH(THREAD_ID_WIDTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_s1),
		.commit(advance),
		.rsp   (next_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_s2 <= next_rsp;
	end

	assign rsp.valid         = valid_s2;
	assign rsp.status        = rsp_s2.status;
	assign rsp.granted_index = rsp_s2.granted_index;
	assign rsp.depth_after   = rsp_s2.depth_after;

endmodule

FILE: tb/recursive_lock_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Recursive lock table testbench
// Drives allocate, free, acquire and release words into the lock pool through
// its request channel and checks every response word against a predictor
// that tracks the used mark, owner and nesting count of each entry. A short
// table of directed words comes first. A short nesting run on one lock
// follows, and then random traffic under several idling patterns.
// ----------------------------------------------------------------------------
module recursive_lock_table_test;
	import rlt_pkg::*;

	localparam int LOCKS = LOCK_COUNT_DEF;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam int DIRECTED_ROWS = 22;
	localparam int NEST_DEPTH = 20;
	localparam int RANDOM_PER_PHASE = 220;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_CAP = 200;

	// One row of the directed table. A row with has_want set carries its
	// expected response; every other row is checked against the predictor.
	// Rows with repeats above one send the same word that many times.
	typedef struct packed {
		mode_t              mode;
		logic [INDEX_W-1:0] lock_index;
		logic [TID_W-1:0]   thread_id;
		logic [4:0]         repeats;
		logic               has_want;
		rsp_t               want;
	} lock_step_t;

	logic clk;
	logic arst_n;

	rlt_req_if req_ch ();
	rlt_rsp_if rsp_ch ();

	recursive_lock_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predictor copy of the pool.
	logic               lock_used  [LOCKS];
	logic [TID_W-1:0]   lock_owner [LOCKS];
	logic [DEPTH_W-1:0] lock_depth [LOCKS];

	// Responses predicted for accepted request words, oldest first.
	rsp_t pending_lock_results [$];

	// Idling percentages for the current phase.
	int req_idle_pct;
	int rsp_stall_pct;

	int mismatch_count;

	logic [TID_W-1:0] thread_pool [4];
	lock_step_t directed_steps [DIRECTED_ROWS];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous limit: the slowest correct run is well under a tenth of a
	// millisecond.
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
		end
	endtask

	// Applies one request to the predictor copy of the pool and returns the
	// response word that the block must give for it.
	function automatic rsp_t predict_lock_result(input mode_t mode,
		input logic [INDEX_W-1:0] idx, input logic [TID_W-1:0] tid);
		rsp_t r;
		bit found;
		r = '{ST_OK, idx, '0};
		found = 1'b0;
		if (mode == MODE_ALLOC) begin
			// Lowest unused entry wins; a full pool reports exhaustion.
			r = '{ST_EXHAUSTED, '0, '0};
			for (int i = 0; i < LOCKS; i++) begin
				if (!found && !lock_used[i]) begin
					found = 1'b1;
					lock_used[i] = 1'b1;
					lock_owner[i] = '0;
					lock_depth[i] = '0;
					r = '{ST_OK, INDEX_W'(i), '0};
				end
			end
			return r;
		end
		if (int'(idx) >= LOCKS) begin
			r.status = ST_ERROR;
			return r;
		end
		r.depth_after = lock_depth[idx];
		if (mode == MODE_FREE) begin
			// Free leaves the owner and the count alone.
			lock_used[idx] = 1'b0;
			return r;
		end
		if (tid == '0) begin
			r.status = ST_ERROR;
			return r;
		end
		if (mode == MODE_ACQUIRE) begin
			if (lock_owner[idx] != tid && lock_owner[idx] != '0) begin
				r.status = ST_BUSY;
			end else if (lock_depth[idx] == DEPTH_MAX) begin
				r.status = ST_ERROR;
			end else begin
				lock_owner[idx] = tid;
				lock_depth[idx] = lock_depth[idx] + 1'b1;
				r.depth_after = lock_depth[idx];
			end
			return r;
		end
		// Release: only the owner of a held lock may step its count down.
		if (lock_owner[idx] != tid || lock_depth[idx] == '0) begin
			r.status = ST_ERROR;
		end else begin
			lock_depth[idx] = lock_depth[idx] - 1'b1;
			if (lock_depth[idx] == '0) begin
				lock_owner[idx] = '0;
			end
			r.depth_after = lock_depth[idx];
		end
		return r;
	endfunction

	// Presents one request word and waits until it is taken. The caller is
	// at a rising edge with no assignment to valid made yet in this step.
	// After acceptance the sender may idle for a random number of cycles.
	task automatic send_lock_word(input mode_t mode, input logic [INDEX_W-1:0] idx,
		input logic [TID_W-1:0] tid, input logic has_want, input rsp_t want);
		rsp_t predicted;
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.lock_index <= idx;
		req_ch.thread_id  <= tid;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_lock_result(mode, idx, tid);
		pending_lock_results.push_back(has_want ? want : predicted);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [TID_W-1:0] pick_thread();
		return thread_pool[$urandom_range(3)];
	endfunction

	// Random traffic. Most words are well formed: acquires by a small set of
	// threads, releases by the current owner, and enough allocates against
	// few frees that the pool keeps running full. The rest is noise.
	task automatic send_random_request();
		int pick;
		mode_t mode;
		logic [INDEX_W-1:0] idx;
		logic [TID_W-1:0] tid;
		pick = $urandom_range(99);
		idx = INDEX_W'($urandom_range(LOCKS - 1));
		tid = pick_thread();
		if (pick < 12) begin
			mode = MODE_ALLOC;
		end else if (pick < 20) begin
			mode = MODE_FREE;
		end else if (pick < 55) begin
			mode = MODE_ACQUIRE;
		end else if (pick < 85) begin
			mode = MODE_RELEASE;
			if (lock_owner[idx] != '0) begin
				tid = lock_owner[idx];
			end
		end else if (pick < 95) begin
			mode = MODE_RELEASE;
		end else begin
			mode = mode_t'(MODE_W'($urandom_range(3)));
			tid = $urandom;
			if ($urandom_range(7) == 0) begin
				tid = '0;
			end
		end
		send_lock_word(mode, idx, tid, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Every response word taken is compared, field by field, with the oldest
	// prediction.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lock_results.size() == 0) begin
				note_mismatch("unexpected response word", '0, 32'({rsp_ch.status,
					rsp_ch.granted_index, rsp_ch.depth_after}));
			end else begin
				want = pending_lock_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					note_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
				end
				if (rsp_ch.granted_index !== want.granted_index) begin
					note_mismatch("granted_index", 32'(want.granted_index),
						32'(rsp_ch.granted_index));
				end
				if (rsp_ch.depth_after !== want.depth_after) begin
					note_mismatch("depth_after", 32'(want.depth_after),
						32'(rsp_ch.depth_after));
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_ALLOC;
		req_ch.lock_index = '0;
		req_ch.thread_id  = '0;
		req_idle_pct      = 0;
		rsp_stall_pct     = 0;
		mismatch_count    = 0;
		for (int i = 0; i < LOCKS; i++) begin
			lock_used[i]  = 1'b0;
			lock_owner[i] = '0;
			lock_depth[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			do thread_pool[i] = $urandom; while (thread_pool[i] == '0);
		end

		// Directed table. Entry 15 is used without being allocated, since the
		// used mark is not checked; it walks through busy, release by another
		// thread, release of an unowned lock and the zero thread id. The pool
		// is then filled to exhaustion, and entry 9 shows that allocate clears
		// an owner and a count that free left behind.
		directed_steps = '{
			'{MODE_ALLOC,   4'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_OK,        4'd0,  16'd0}},
			'{MODE_FREE,    4'd15, 32'h0000_0001, 5'd1,  1'b1, '{ST_OK,        4'd15, 16'd0}},
			'{MODE_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,        4'd15, 16'd1}},
			'{MODE_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b0, '0},
			'{MODE_ACQUIRE, 4'd15, 32'h0000_0001, 5'd1,  1'b1, '{ST_BUSY,      4'd15, 16'd2}},
			'{MODE_RELEASE, 4'd15, 32'h0000_0001, 5'd1,  1'b1, '{ST_ERROR,     4'd15, 16'd2}},
			'{MODE_RELEASE, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b0, '0},
			'{MODE_RELEASE, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b0, '0},
			'{MODE_RELEASE, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_ERROR,     4'd15, 16'd0}},
			'{MODE_ACQUIRE, 4'd15, 32'h0000_0000, 5'd1,  1'b1, '{ST_ERROR,     4'd15, 16'd0}},
			'{MODE_RELEASE, 4'd15, 32'h0000_0000, 5'd1,  1'b1, '{ST_ERROR,     4'd15, 16'd0}},
			'{MODE_ALLOC,   4'd0,  32'h0000_0001, 5'd15, 1'b0, '0},
			'{MODE_ALLOC,   4'd6,  32'h0000_0001, 5'd1,  1'b1, '{ST_EXHAUSTED, 4'd0,  16'd0}},
			'{MODE_FREE,    4'd7,  32'h5555_5555, 5'd1,  1'b1, '{ST_OK,        4'd7,  16'd0}},
			'{MODE_ALLOC,   4'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_OK,        4'd7,  16'd0}},
			'{MODE_ACQUIRE, 4'd9,  32'hAAAA_AAAA, 5'd1,  1'b1, '{ST_OK,        4'd9,  16'd1}},
			'{MODE_FREE,    4'd9,  32'h0000_0001, 5'd1,  1'b0, '0},
			'{MODE_ALLOC,   4'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_OK,        4'd9,  16'd0}},
			'{MODE_ACQUIRE, 4'd9,  32'h8000_0001, 5'd1,  1'b0, '0},
			'{MODE_ACQUIRE, 4'd9,  32'hAAAA_AAAA, 5'd1,  1'b0, '0},
			'{MODE_RELEASE, 4'd9,  32'h8000_0001, 5'd1,  1'b0, '0},
			'{MODE_FREE,    4'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_OK,        4'd0,  16'd0}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			for (int n = 0; n < int'(directed_steps[row].repeats); n++) begin
				send_lock_word(directed_steps[row].mode, directed_steps[row].lock_index,
					directed_steps[row].thread_id, directed_steps[row].has_want,
					directed_steps[row].want);
			end
		end

		// Nest one lock NEST_DEPTH levels deep, then unwind it to zero again.
		// Run flat out.
		for (int n = 0; n < NEST_DEPTH; n++) begin
			send_lock_word(MODE_ACQUIRE, 4'd2, 32'hA5A5_5A5A, 1'b0, '0);
		end
		for (int n = 0; n < NEST_DEPTH; n++) begin
			send_lock_word(MODE_RELEASE, 4'd2, 32'hA5A5_5A5A, 1'b0, '0);
		end

		// Random traffic under each idling pattern in turn.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					req_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					req_idle_pct = 81;
					rsp_stall_pct = 0;
				end
				2: begin
					req_idle_pct = 0;
					rsp_stall_pct = 81;
				end
				default: begin
					req_idle_pct = 21;
					rsp_stall_pct = 21;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_random_request();
		end

		req_ch.valid <= 1'b0;
		while (pending_lock_results.size() != 0) @(posedge clk);
		// Idle on afterwards so a stray extra word would still be seen.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
